### rtl/hash_equivalence_class_table_defines.svh
// Assertion macros shared by the equivalence-class table RTL.
`ifndef HASH_EQUIVALENCE_CLASS_TABLE_DEFINES_SVH
`define HASH_EQUIVALENCE_CLASS_TABLE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define HECT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define HECT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/hect_pkg.sv
// Shared types and codes of the equivalence-class table.
`default_nettype none
package hect_pkg;
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_JOINED    = 3'd1;
    localparam logic [2:0] ST_HIT       = 3'd2;
    localparam logic [2:0] ST_MISS      = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_EXHAUSTED = 3'd5;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam int KeyW   = 64;
    localparam int HashW  = 32;
    localparam int ClassW = 11;
    localparam logic signed [ClassW-1:0] NoClass = '1;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BE_CLEAR,
        BE_IDLE,
        BE_READ,
        BE_CHECK,
        BE_EMIT
    } be_state_t;
endpackage
`default_nettype wire

### rtl/hect_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module hect_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/hect_front.sv
// Front end: accepts commands into a short queue toward the probe engine.
`default_nettype none
module hect_front #(
    parameter int KW = 64,
    parameter int HW = 32,
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          in_cmd,
    input  wire logic [KW-1:0] in_key,
    input  wire logic [HW-1:0] in_hash,
    output logic               q_valid,
    input  wire logic          q_pop,
    output logic               q_cmd,
    output logic [KW-1:0]      q_key,
    output logic [HW-1:0]      q_hash
);
    import hect_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [KW+HW:0] fifo_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           push;

    assign in_stall = (cnt_reg == (AW+1)'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign {q_cmd, q_key, q_hash} = fifo_reg[rp_reg];

    // Queue storage; the command is classified by its cmd bit in the back end.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wp_reg] <= {in_cmd, in_key, in_hash};
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end
endmodule
`default_nettype wire

### rtl/hect_back.sv
// Back end: probes the table, updates slots and emits results.
`default_nettype none
`include "hash_equivalence_class_table_defines.svh"
module hect_back #(
    parameter int TABLE_SIZE  = 1024,
    parameter int MAX_CLASSES = 1024,
    parameter int KW = 64,
    parameter int HW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [9:0]    fill_limit,
    output logic               busy,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  wire logic          q_cmd,
    input  wire logic [KW-1:0] q_key,
    input  wire logic [HW-1:0] q_hash,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [2:0]         status,
    output logic signed [hect_pkg::ClassW-1:0] class_id,
    output logic [hect_pkg::KeyW-1:0] member_key,
    output logic               last
);
    import hect_pkg::*;
    localparam int SW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(MAX_CLASSES + 1);
    localparam int EW = $clog2(TABLE_SIZE + 1);
    // Slot word: valid, class, hash, key.
    localparam int RW = 1 + ClassW + HW + KW;

    be_state_t       state_reg, state_next;
    logic [SW-1:0]   pos_reg, pos_next;
    logic [SW:0]     nprobe_reg, nprobe_next;
    logic [EW-1:0]   entry_reg, entry_next;
    logic [CW-1:0]   class_reg, class_next;
    logic            second_reg, second_next;
    logic [2:0]      st_reg, st_next;
    logic signed [ClassW-1:0] cid_reg, cid_next;
    logic [KW-1:0]   mk_reg, mk_next;
    logic            last_reg, last_next;
    logic [KW-1:0]   key2_reg, key2_next;

    logic            we;
    logic [SW-1:0]   waddr, raddr;
    logic [RW-1:0]   wdata, rdata;
    logic            r_val;
    logic signed [ClassW-1:0] r_cls;
    logic [HW-1:0]   r_hash;
    logic [KW-1:0]   r_key;

    hect_ram #(.WIDTH(RW), .DEPTH(TABLE_SIZE)) u_slots (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );
    assign {r_val, r_cls, r_hash, r_key} = rdata;

    assign out_valid  = (state_reg == BE_EMIT);
    assign status     = st_reg;
    assign class_id   = cid_reg;
    assign member_key = mk_reg;
    assign last       = last_reg;
    assign busy       = (state_reg != BE_IDLE) || q_valid;
    assign raddr      = pos_next;

    // Clocked state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BE_CLEAR;
            pos_reg    <= '0;
            nprobe_reg <= '0;
            entry_reg  <= '0;
            class_reg  <= '0;
            second_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            nprobe_reg <= nprobe_next;
            entry_reg  <= entry_next;
            class_reg  <= class_next;
            second_reg <= second_next;
            last_reg   <= last_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        cid_reg  <= cid_next;
        mk_reg   <= mk_next;
        key2_reg <= key2_next;
    end

    // Probe sequencer: a mismatching slot moves the probe on to the next slot, through BE_READ back to BE_CHECK.
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        nprobe_next = nprobe_reg;
        entry_next  = entry_reg;
        class_next  = class_reg;
        second_next = second_reg;
        st_next     = st_reg;
        cid_next    = cid_reg;
        mk_next     = mk_reg;
        last_next   = last_reg;
        key2_next   = key2_reg;
        q_pop       = 1'b0;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = '0;
        case (state_reg)
            BE_CLEAR:
            begin
                we       = 1'b1;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == SW'(TABLE_SIZE-1))
                begin
                    state_next = BE_IDLE;
                end
            end
            BE_IDLE:
            begin
                if (q_valid)
                begin
                    pos_next    = q_hash[SW-1:0];
                    nprobe_next = '0;
                    state_next  = BE_CHECK;
                end
            end
            BE_READ:
            begin
                state_next = BE_CHECK;
            end
            BE_CHECK:
            begin
                mk_next     = '0;
                last_next   = 1'b1;
                second_next = 1'b0;
                if (nprobe_reg == (SW+1)'(TABLE_SIZE))
                begin
                    st_next    = (q_cmd == CMD_LOOKUP) ? ST_MISS : ST_FULL;
                    cid_next   = NoClass;
                    q_pop      = 1'b1;
                    state_next = BE_EMIT;
                end
                else if (!r_val)
                begin
                    cid_next   = NoClass;
                    q_pop      = 1'b1;
                    state_next = BE_EMIT;
                    if (q_cmd == CMD_LOOKUP)
                    begin
                        st_next = ST_MISS;
                    end
                    else if ((EW'(entry_reg) >= EW'(fill_limit))
                             || (entry_reg >= EW'(TABLE_SIZE-1)))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        st_next    = ST_STORED;
                        we         = 1'b1;
                        wdata      = {1'b1, NoClass, q_hash, q_key};
                        entry_next = entry_reg + 1'b1;
                    end
                end
                else if (r_hash == q_hash && r_key == q_key)
                begin
                    q_pop      = 1'b1;
                    state_next = BE_EMIT;
                    if (q_cmd == CMD_LOOKUP)
                    begin
                        st_next  = ST_HIT;
                        cid_next = r_cls;
                    end
                    else if (!r_cls[ClassW-1])
                    begin
                        st_next  = ST_JOINED;
                        cid_next = r_cls;
                        mk_next  = q_key;
                    end
                    else if (class_reg >= CW'(MAX_CLASSES))
                    begin
                        st_next  = ST_EXHAUSTED;
                        cid_next = NoClass;
                    end
                    else
                    begin
                        st_next     = ST_JOINED;
                        cid_next    = ClassW'(class_reg);
                        mk_next     = r_key;
                        key2_next   = q_key;
                        last_next   = 1'b0;
                        second_next = 1'b1;
                        class_next  = class_reg + 1'b1;
                        we          = 1'b1;
                        wdata       = {1'b1, ClassW'(class_reg), r_hash, r_key};
                    end
                end
                else
                begin
                    pos_next    = pos_reg + 1'b1;
                    nprobe_next = nprobe_reg + 1'b1;
                    state_next  = BE_READ;
                end
            end
            BE_EMIT:
            begin
                if (!out_stall)
                begin
                    if (second_reg)
                    begin
                        second_next = 1'b0;
                        mk_next     = key2_reg;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = BE_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BE_IDLE;
            end
        endcase
    end

    `HECT_ASSERT_IMPL(a_pop_only_in_check, clk, rst_n, q_pop, state_reg == BE_CHECK, "pop outside check")
    `HECT_ASSERT_IMPL(a_second_not_last, clk, rst_n, out_valid && second_reg, !last_reg, "first of pair marked last")
    `HECT_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(mk_reg), "result dropped under stall")
endmodule
`default_nettype wire

### rtl/hash_equivalence_class_table.sv
// Top level of the equivalence-class hash table.
//
// Input channel: in_valid/in_stall with cmd, key and hash. Output channel:
// out_valid/out_stall with status, class_id, member_key and last. A
// transaction moves when valid is high and stall is low. The fill_limit
// register is written over cfg_valid/cfg_ready; the user must write it
// only while the block is idle, which the block itself leaves unchecked.
// Inputs enter a two-entry queue; the probe engine reads the slots from
// the slot RAM one after another, each further probe passing through
// BE_READ and BE_CHECK, and each result is held in BE_EMIT. A new class
// gives two results, the stored key first. After reset a clearing pass
// writes every slot of the slot RAM empty; inputs queue but are not
// processed until it ends. A stalled receiver holds the result, the
// engine waits and the queue then fills and stalls the sender.
`default_nettype none
module hash_equivalence_class_table #(
    parameter int TABLE_SIZE  = 1024,
    parameter int MAX_CLASSES = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [63:0] key,
    input  wire logic [31:0] hash,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic signed [10:0] class_id,
    output logic [63:0]      member_key,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data
);
    import hect_pkg::*;

    logic [9:0]  fill_limit_reg;
    logic        busy, q_valid, q_pop, q_cmd;
    logic [63:0] q_key;
    logic [31:0] q_hash;

    assign cfg_ready = 1'b1;

    // Fill limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_limit_reg <= 10'd768;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fill_limit_reg <= cfg_data;
        end
    end

    hect_front #(.KW(KeyW), .HW(HashW), .DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_cmd(cmd), .in_key(key), .in_hash(hash),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .q_key(q_key),
        .q_hash(q_hash)
    );

    hect_back #(.TABLE_SIZE(TABLE_SIZE), .MAX_CLASSES(MAX_CLASSES),
                .KW(KeyW), .HW(HashW)) u_back (
        .clk(clk), .rst_n(rst_n), .fill_limit(fill_limit_reg), .busy(busy),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .q_key(q_key),
        .q_hash(q_hash), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .class_id(class_id), .member_key(member_key),
        .last(last)
    );

    `HECT_ASSERT_IMPL(a_pop_needs_item, clk, rst_n, q_pop, q_valid, "pop from empty queue")
    `HECT_ASSERT_IMPL(a_out_busy, clk, rst_n, out_valid, busy, "result while idle")
    `HECT_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, status <= ST_EXHAUSTED, "bad status")
endmodule
`default_nettype wire
